[design/assert_macros.svh]
// Assertion macros used by the match stage of the search core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define WBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/wbps_pkg.sv]
// Shared types and constants of the wildcard byte pattern search core.
// No dependencies.
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 48;
  localparam int WIN_DEPTH         = MAX_PATTERN_BYTES;
  localparam int LEN_W             = 6;
  localparam int CNT_W             = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int WORD_BYTES        = CFG_DATA_W / 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT0 = 3'd0,
    CFG_PAT1 = 3'd1,
    CFG_PAT2 = 3'd2,
    CFG_PAT3 = 3'd3,
    CFG_PAT4 = 3'd4,
    CFG_PAT5 = 3'd5,
    CFG_MASK = 3'd6,
    CFG_LEN  = 3'd7
  } cfg_idx_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_DEPTH-1:0] win_t;

  typedef struct packed {
    win_t                 exp;
    logic [WIN_DEPTH-1:0] care;
    logic [LEN_W-1:0]     len_m1;
    logic                 len_ok;
  } pat_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CNT_W-1:0] idx;
  } s1_t;

endpackage

[design/wbps_if.sv]
// Word channel interfaces of the search core: byte input and result output.
// Depends on nothing.
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[design/wbps_cfg.sv]
// Configuration registers and pattern alignment against the byte window.
// Depends on wbps_pkg.
module wbps_cfg import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pat_t                  pat
);

  byte_t [MAX_PATTERN_BYTES-1:0] pat_r;
  logic  [MAX_PATTERN_BYTES-1:0] mask_r;
  logic  [LEN_W-1:0]             len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      mask_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAT0: pat_r[0*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_PAT1: pat_r[1*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_PAT2: pat_r[2*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_PAT3: pat_r[3*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_PAT4: pat_r[4*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_PAT5: pat_r[5*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        CFG_MASK: mask_r <= cfg_data[MAX_PATTERN_BYTES-1:0];
        CFG_LEN:  len_r  <= cfg_data[LEN_W-1:0];
        default:  len_r  <= len_r;
      endcase
    end
  end

  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] j;

  assign len_m1 = len_r - LEN_W'(1);

  // Window entry k holds the byte that lines up with pattern byte len-1-k.
  always_comb begin
    j          = '0;
    pat.exp    = '0;
    pat.care   = '0;
    pat.len_m1 = len_m1;
    pat.len_ok = (len_r != '0) && (len_r <= LEN_W'(MAX_PATTERN_BYTES));
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (pat.len_ok && (LEN_W'(k) < len_r)) begin
        j           = len_m1 - LEN_W'(k);
        pat.exp[k]  = pat_r[j];
        pat.care[k] = !mask_r[j];
      end
    end
  end

endmodule

[design/wbps_window.sv]
// Input stage: accepts bytes, shifts the window and counts buffer bytes.
// Depends on wbps_pkg and wbps_in_if.
module wbps_window import wbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_ch,
  input  logic       pipe_en,
  output s1_t        s1,
  output win_t       win
);

  logic             s1_v_r, s1_v_nxt;
  logic             last_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             prev_last_r;
  win_t             win_r, win_nxt;
  win_t             win_base;
  logic [CNT_W-1:0] cnt_base;
  logic             accept;

  assign in_ch.ready = !s1_v_r || pipe_en;
  assign accept      = in_ch.valid && in_ch.ready;

  // A word after the last word of a buffer starts from a cleared window and count.
  assign win_base = prev_last_r ? '0 : win_r;
  assign cnt_base = prev_last_r ? '0 : cnt_r;
  assign win_nxt  = {win_base[WIN_DEPTH-2:0], in_ch.data_byte};
  assign cnt_nxt  = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + CNT_W'(1);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (pipe_en) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      prev_last_r <= 1'b1;
      cnt_r       <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (accept) begin
        prev_last_r <= in_ch.last_byte;
        cnt_r       <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r  <= win_nxt;
      idx_r  <= cnt_base;
      last_r <= in_ch.last_byte;
    end
  end

  assign s1.valid = s1_v_r;
  assign s1.last  = last_r;
  assign s1.idx   = idx_r;
  assign win      = win_r;

endmodule

[design/wbps_match.sv]
// Match stage: masked compare over the window, first-match latch, result register.
// Depends on wbps_pkg, wbps_out_if and assert_macros.svh.
`include "assert_macros.svh"
module wbps_match import wbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  s1_t        s1,
  input  win_t       win,
  input  pat_t       pat,
  output logic       pipe_en,
  wbps_out_if.source out_ch
);

  logic             latched_r, latched_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic             out_v_r, out_v_nxt;
  logic             found_r;
  logic [CNT_W-1:0] off_r;
  logic             consume;
  logic             all_eq;
  logic             hit;
  logic             set;
  logic             lat_now;
  logic [CNT_W-1:0] first_now;

  assign pipe_en = !out_v_r || out_ch.ready;
  assign consume = s1.valid && pipe_en;

  always_comb begin
    all_eq = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (pat.care[k] && (win[k] != pat.exp[k])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign hit = pat.len_ok && (s1.idx != COUNT_MAX) &&
               (s1.idx >= CNT_W'(pat.len_m1)) && all_eq;
  assign set       = !latched_r && hit;
  assign lat_now   = latched_r || set;
  assign first_now = set ? (s1.idx - CNT_W'(pat.len_m1)) : first_r;

  always_comb begin
    latched_nxt = latched_r;
    first_nxt   = first_r;
    out_v_nxt   = out_v_r;
    if (consume && s1.last) begin
      latched_nxt = 1'b0;
      first_nxt   = '0;
      out_v_nxt   = 1'b1;
    end else begin
      if (consume) begin
        latched_nxt = lat_now;
        first_nxt   = first_now;
      end
      if (out_ch.ready) begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      latched_r <= latched_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    if (consume && s1.last) begin
      found_r <= lat_now;
      off_r   <= lat_now ? first_now : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.found        = found_r;
  assign out_ch.match_offset = off_r;

  `WBPS_ASSERT(a_nf_zero_off, clk, rst_n, (out_v_r && !found_r) |-> (off_r == '0), "offset set without a match")
  `WBPS_ASSERT(a_end_clears, clk, rst_n, (consume && s1.last) |=> !latched_r, "latch survived buffer end")
  `WBPS_ASSERT(a_latch_holds, clk, rst_n, (latched_r && !(consume && s1.last)) |=> latched_r, "latch dropped mid-buffer")

endmodule

[design/wildcard_byte_pattern_search_core.sv]
// Top level of the wildcard byte pattern search core.
// Depends on wbps_pkg, wbps_if, wbps_cfg, wbps_window and wbps_match.
//
// Channel   Direction  Payload                       Word
// in_ch     sink       data_byte[7:0], last_byte     one buffer byte
// out_ch    source     found, match_offset[31:0]     one result per buffer
// cfg_*     write      cfg_index[2:0], cfg_data[63:0] one register
//
// One byte is accepted every cycle unless a waiting result stalls the pipeline; after the
// last byte of a buffer, its result passes the window register and then the result register.
// Reset is synchronous and active low; it clears the registers and the latch, not the window.
// A waiting result stalls the compare stage, and the input holds off only once it is full.
module wildcard_byte_pattern_search_core import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if.sink               in_ch,
  wbps_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pat_t pat;
  s1_t  s1;
  win_t win;
  logic pipe_en;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  wbps_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .pipe_en (pipe_en),
    .s1      (s1),
    .win     (win)
  );

  wbps_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1),
    .win     (win),
    .pat     (pat),
    .pipe_en (pipe_en),
    .out_ch  (out_ch)
  );

endmodule

[tb/sv/wbps_result_checker.sv]
`timescale 1ns / 1ps
// Result checker of the wildcard byte pattern search core: it predicts each buffer's outcome
// from the accepted bytes and register writes and compares it with the result channel.
// Depends on wbps_pkg and the channel interfaces in wbps_if.
module wbps_result_checker import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if                    in_ch,
  wbps_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           results_due
);

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] match_offset;
  } search_result_t;

  logic [CFG_DATA_W-1:0] pat_words [6];
  logic [47:0]           wild_bits;
  logic [LEN_W-1:0]      pat_len;
  byte_t                 recent_window [WIN_DEPTH];
  logic [CNT_W-1:0]      seen_count;
  logic                  hit_latched;
  logic [CNT_W-1:0]      hit_offset;
  search_result_t        expected_results [$];
  int unsigned           mismatch_count = 0;

  assign fail_count = mismatch_count;

  always @(posedge clk) begin : search_monitor
    search_result_t   want;
    logic [CNT_W-1:0] idx;
    logic             hit;
    int               j;
    if (!rst_n) begin
      for (j = 0; j < 6; j++) pat_words[j] = '0;
      wild_bits = '0;
      pat_len = '0;
      for (j = 0; j < WIN_DEPTH; j++) recent_window[j] = '0;
      seen_count = '0;
      hit_latched = 1'b0;
      hit_offset = '0;
      expected_results.delete();
      results_due <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: found %0d match_offset %0d",
                 out_ch.found, out_ch.match_offset);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_ch.found);
            mismatch_count++;
          end
          if (out_ch.match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, actual %0d",
                   want.match_offset, out_ch.match_offset);
            mismatch_count++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3, CFG_PAT4, CFG_PAT5: begin
            pat_words[cfg_index] = cfg_data;
          end
          CFG_MASK: begin
            wild_bits = cfg_data[47:0];
          end
          CFG_LEN: begin
            pat_len = cfg_data[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        idx = seen_count;
        for (j = WIN_DEPTH - 1; j > 0; j--) recent_window[j] = recent_window[j-1];
        recent_window[0] = in_ch.data_byte;
        hit = !hit_latched && idx != COUNT_MAX && pat_len != 0 &&
              int'(pat_len) <= MAX_PATTERN_BYTES && idx >= CNT_W'(pat_len) - 1;
        for (j = 0; j < MAX_PATTERN_BYTES; j++) begin
          if (hit && j < int'(pat_len) && !wild_bits[j] &&
              recent_window[int'(pat_len) - 1 - j] != pat_words[j/8][8*(j%8) +: 8]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          hit_latched = 1'b1;
          hit_offset = idx - (CNT_W'(pat_len) - 1);
        end
        if (seen_count != COUNT_MAX) seen_count = seen_count + 1;
        if (in_ch.last_byte) begin
          want.found = hit_latched;
          want.match_offset = hit_latched ? hit_offset : '0;
          expected_results = {expected_results, want};
          for (j = 0; j < WIN_DEPTH; j++) recent_window[j] = '0;
          seen_count = '0;
          hit_latched = 1'b0;
          hit_offset = '0;
        end
      end
      results_due <= expected_results.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top of the wildcard byte pattern search core: clock, reset, register writes,
// byte streams with idling on both channels, and the verdict.
// Depends on wbps_pkg, wbps_if, the core and wbps_result_checker.
module tb_top;
  import wbps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_BYTES = 150;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_ready_r = 1'b0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           cycle_count = 0;
  int unsigned           fail_count;
  int unsigned           results_due;

  // The pattern as last written, kept only to shape the byte streams.
  byte_t                 pat_bytes [MAX_PATTERN_BYTES];
  logic [47:0]           pat_wild;
  int unsigned           pat_len = 0;
  byte_t                 stream_q [$];

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wbps_result_checker result_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #2 clk = ~clk;

  assign out_ch.ready = out_ready_r;

  always @(posedge clk) begin
    out_ready_r <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wildcard_byte_pattern_search_core verification failed");
      $finish;
    end
  end

  task automatic load_pattern(input logic [CFG_DATA_W-1:0] words [6], input logic [47:0] wild,
                              input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] d;
    int i;
    for (i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(int'(CFG_PAT0) + i);
      cfg_data <= words[i];
      @(posedge clk);
    end
    d = {$urandom, $urandom};
    d[47:0] = wild;
    cfg_index <= CFG_MASK;
    cfg_data <= d;
    @(posedge clk);
    d = {$urandom, $urandom};
    d[LEN_W-1:0] = len;
    cfg_index <= CFG_LEN;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (i = 0; i < MAX_PATTERN_BYTES; i++) pat_bytes[i] = words[i/8][8*(i%8) +: 8];
    pat_wild = wild;
    pat_len = len;
  endtask

  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic send_word(input byte_t b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) send_word(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Bytes drawn mostly from the pattern, with whole copies planted and some copies broken.
  task automatic fill_stream();
    int unsigned n, eff_len, start, copies, c, j;
    eff_len = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pat_len;
    if (eff_len != 0 && $urandom_range(3) != 0) n = eff_len + $urandom_range(0, 24);
    else n = $urandom_range(1, 20);
    stream_q.delete();
    for (j = 0; j < n; j++) begin
      if (eff_len == 0 || $urandom_range(2) == 0) stream_q = {stream_q, byte_t'($urandom)};
      else stream_q = {stream_q, pat_bytes[$urandom_range(eff_len - 1)]};
    end
    if (eff_len != 0 && n >= eff_len) begin
      copies = $urandom_range(0, 2);
      for (c = 0; c < copies; c++) begin
        start = $urandom_range(n - eff_len);
        for (j = 0; j < eff_len; j++) begin
          stream_q[start + j] = pat_wild[j] ? byte_t'($urandom) : pat_bytes[j];
        end
        if ($urandom_range(4) == 0) begin
          j = start + $urandom_range(eff_len - 1);
          stream_q[j] = stream_q[j] ^ byte_t'(8'h01 << $urandom_range(7));
        end
      end
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] words [6];
    logic [47:0]           wild;
    logic [LEN_W-1:0]      len;
    int                    p, i, sent, streams;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PAT0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset give an empty pattern, which never matches.
    stream_q = {8'h00, 8'h00};
    send_stream();
    drain(8);

    words[0] = 64'hFFFF_FFFF_4433_2211;
    for (i = 1; i < 6; i++) words[i] = '0;
    load_pattern(words, 48'h0000_0000_0002, LEN_W'(4));
    stream_q = {8'h11, 8'h22, 8'h33};
    send_stream();
    stream_q = {8'h11, 8'hFF, 8'h33, 8'h44};
    send_stream();
    stream_q = {8'h00, 8'hFF, 8'h11, 8'hAA, 8'h33, 8'h44, 8'h11, 8'h00, 8'h33, 8'h44};
    send_stream();
    drain(8);

    // A length above the window never matches.
    load_pattern(words, 48'h0000_0000_0002, LEN_W'(49));
    stream_q = {8'h11, 8'h22, 8'h33, 8'h44};
    send_stream();

    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      for (i = 0; i < 6; i++) words[i] = {$urandom, $urandom};
      wild = 48'({$urandom, $urandom});
      case (p)
        0: begin
          wild = '0;
          len = LEN_W'(MAX_PATTERN_BYTES);
        end
        1: begin
          for (i = 0; i < 6; i++) words[i] = '1;
          wild = '1;
          len = LEN_W'(1);
        end
        2: begin
          wild = wild & 48'({$urandom, $urandom});
          len = LEN_W'($urandom_range(1, 12));
        end
        3: begin
          for (i = 0; i < 6; i++) words[i] = '0;
          wild = '0;
          len = '1;
        end
        4: len = LEN_W'($urandom_range(2, MAX_PATTERN_BYTES));
        5: len = '0;
        6: begin
          for (i = 0; i < 6; i++) words[i] = '0;
          wild = '0;
          len = LEN_W'($urandom_range(1, 8));
        end
        default: len = LEN_W'($urandom_range(1, MAX_PATTERN_BYTES));
      endcase
      drain(8);
      load_pattern(words, wild, len);
      sent = 0;
      streams = 0;
      while (sent < PHASE_BYTES) begin
        fill_stream();
        send_stream();
        sent += stream_q.size();
        streams++;
        if (p == 4 && streams == 1) drain(0);
      end
    end

    drain(10);
    if (fail_count == 0 && results_due == 0) begin
      $display("wildcard_byte_pattern_search_core verification clean");
    end else begin
      $display("wildcard_byte_pattern_search_core verification failed");
    end
    $finish;
  end

endmodule
